[rtl/core/directional_object_counter_top_assert.svh]
// Assertion macros for the directional object counter checker.
// Included by doc_chk.sv; needs a clock i_clk and reset i_rst_n in scope.
`ifndef DIRECTIONAL_OBJECT_COUNTER_TOP_ASSERT_SVH
`define DIRECTIONAL_OBJECT_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DOC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("doc_chk: assertion failed");

// Next-cycle implication, disabled in reset.
`define DOC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("doc_chk: assertion failed");

`endif

[rtl/core/doc_pkg.sv]
// Shared constants, register codes and word types of the directional object counter.
// No dependencies.
`default_nettype none

package doc_pkg;

    localparam int RECENT_DEPTH = 16;
    localparam int COORD_BITS   = 12;
    localparam int ID_BITS      = 16;
    localparam int FRAME_BITS   = 16;
    localparam int CNT_BITS     = 32;
    localparam int IDX_BITS     = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int CFG_IDX_BITS = 2;
    localparam int MIN_FRAMES   = 2;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                  kind;
        logic [ID_BITS-1:0]    object_id;
        logic [FRAME_BITS-1:0] frames_alive;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] object_width;
        logic                  left_to_right;
    } t_in;

    typedef struct packed {
        logic                counted;
        logic [CNT_BITS-1:0] ltr_count;
        logic [CNT_BITS-1:0] rtl_count;
        logic [CNT_BITS:0]   total_count;
    } t_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] ref_left;
        logic [COORD_BITS-1:0] ref_top;
        logic [COORD_BITS-1:0] ref_width;
        logic [COORD_BITS-1:0] ref_height;
    } t_cfg;

    typedef struct packed {
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [ID_BITS-1:0]  wr_id;
    } t_ring_req;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               valid;
    } t_ring_rsp;

endpackage

`default_nettype wire

[rtl/core/doc_ring.sv]
// Ring of recently counted ids: synchronous id RAM, valid flags and write pointer.
// Depends on doc_pkg.
`default_nettype none

module doc_ring (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  doc_pkg::t_ring_req  i_req,
    output doc_pkg::t_ring_rsp  o_rsp
);

    localparam logic [doc_pkg::IDX_BITS-1:0] LAST_IDX =
        doc_pkg::IDX_BITS'(doc_pkg::RECENT_DEPTH - 1);

    logic [doc_pkg::ID_BITS-1:0]      mem [doc_pkg::RECENT_DEPTH];
    logic [doc_pkg::ID_BITS-1:0]      r_rd_id;
    logic                             r_rd_vld;
    logic [doc_pkg::RECENT_DEPTH-1:0] r_valid;
    logic [doc_pkg::IDX_BITS-1:0]     r_ptr;
    logic [doc_pkg::IDX_BITS-1:0]     n_ptr;

    always_comb begin
        n_ptr = r_ptr;
        if (i_req.wr_en) begin
            n_ptr = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
        end
    end

    // The sequencer never writes while a scan is in flight, so no forwarding.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[r_ptr] <= i_req.wr_id;
        end
        if (i_req.rd_en) begin
            r_rd_id <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[r_ptr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
            r_ptr <= n_ptr;
        end
    end

    assign o_rsp.id    = r_rd_id;
    assign o_rsp.valid = r_rd_vld;

endmodule

`default_nettype wire

[rtl/core/doc_qual.sv]
// Qualification tests of a report (age, travel, size, box), registered.
// Depends on doc_pkg.
`default_nettype none

module doc_qual (
    input  wire            i_clk,
    input  doc_pkg::t_in   i_item,
    input  doc_pkg::t_cfg  i_cfg,
    output logic           o_pass
);

    localparam int CB = doc_pkg::COORD_BITS;

    logic [CB-1:0] travel;
    logic [CB+4:0] w20;
    logic [CB+4:0] ref13;
    logic [CB+1:0] w2;
    logic [CB+1:0] ref3;
    logic [CB:0]   right_edge;
    logic [CB:0]   bottom_edge;
    logic          age_ok;
    logic          travel_ok;
    logic          size_ok;
    logic          box_ok;
    logic          r_pass;

    always_comb begin
        travel = (i_item.pos_x >= i_item.start_x) ? i_item.pos_x - i_item.start_x
                                                  : i_item.start_x - i_item.pos_x;
        // 0.65 < w/W < 1.5 tested as 20w > 13W and 2w < 3W
        w20   = (CB+5)'(i_item.object_width) * (CB+5)'(20);
        ref13 = (CB+5)'(i_cfg.ref_width) * (CB+5)'(13);
        w2    = (CB+2)'(i_item.object_width) << 1;
        ref3  = (CB+2)'(i_cfg.ref_width) * (CB+2)'(3);
        right_edge  = (CB+1)'(i_cfg.ref_left) + (CB+1)'(i_cfg.ref_width);
        bottom_edge = (CB+1)'(i_cfg.ref_top) + (CB+1)'(i_cfg.ref_height);

        age_ok    = i_item.frames_alive > doc_pkg::FRAME_BITS'(doc_pkg::MIN_FRAMES);
        travel_ok = travel > i_cfg.ref_width;
        size_ok   = (w20 > ref13) && (w2 < ref3);
        box_ok    = (i_item.pos_x > i_cfg.ref_left)
                 && ((CB+1)'(i_item.pos_x) < right_edge)
                 && (i_item.pos_y > i_cfg.ref_top)
                 && ((CB+1)'(i_item.pos_y) < bottom_edge);
    end

    always_ff @(posedge i_clk) begin
        r_pass <= age_ok && travel_ok && size_ok && box_ok;
    end

    assign o_pass = r_pass;

endmodule

`default_nettype wire

[rtl/core/directional_object_counter_top.sv]
// Channel    Dir  Handshake              Word
// item       in   start & !busy          i_item (doc_pkg::t_in)
// result     out  o_valid, one cycle     o_result (doc_pkg::t_out)
// config     in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// A report scans the id RAM one entry per cycle over its single read port, then
// decides in S_LAST; busy is high in S_SCAN and S_LAST, and the result is registered.
// A clear word gives its result the cycle after accept and never raises busy.
// Synchronous active-low reset clears counters, valid flags and pointer; no RAM sweep.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Depends on doc_pkg, doc_ring, doc_qual.
`default_nettype none

module directional_object_counter_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  doc_pkg::t_in                        i_item,
    output logic                                o_valid,
    output doc_pkg::t_out                       o_result,
    input  wire                                 i_cfg_we,
    input  wire  [doc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire  [doc_pkg::COORD_BITS-1:0]      i_cfg_data
);

    localparam logic [doc_pkg::IDX_BITS-1:0] LAST_IDX =
        doc_pkg::IDX_BITS'(doc_pkg::RECENT_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } t_state;

    t_state                          r_state, n_state;
    logic [doc_pkg::IDX_BITS-1:0]    r_addr, n_addr;
    logic                            r_hit, n_hit;
    logic                            r_cmp, n_cmp;
    doc_pkg::t_in                    r_item, n_item;
    logic [doc_pkg::CNT_BITS-1:0]    r_ltr, n_ltr;
    logic [doc_pkg::CNT_BITS-1:0]    r_rtl, n_rtl;
    doc_pkg::t_out                   r_out, n_out;
    logic                            r_out_vld, n_out_vld;
    doc_pkg::t_cfg                   r_cfg;
    doc_pkg::t_ring_req              ring_req;
    doc_pkg::t_ring_rsp              ring_rsp;
    logic                            qual_pass;
    logic                            cmp_hit;
    logic                            do_result;
    logic                            counted;

    doc_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ring_req),
        .o_rsp   (ring_rsp)
    );

    doc_qual u_qual (
        .i_clk  (i_clk),
        .i_item (r_item),
        .i_cfg  (r_cfg),
        .o_pass (qual_pass)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (doc_pkg::t_reg_idx'(i_cfg_idx))
                doc_pkg::REG_LEFT:   r_cfg.ref_left   <= i_cfg_data;
                doc_pkg::REG_TOP:    r_cfg.ref_top    <= i_cfg_data;
                doc_pkg::REG_WIDTH:  r_cfg.ref_width  <= i_cfg_data;
                doc_pkg::REG_HEIGHT: r_cfg.ref_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_hit     = r_hit;
        n_cmp     = 1'b0;
        n_item    = r_item;
        n_ltr     = r_ltr;
        n_rtl     = r_rtl;
        do_result = 1'b0;
        counted   = 1'b0;

        ring_req         = '0;
        ring_req.rd_addr = r_addr;
        ring_req.wr_id   = r_item.object_id;

        // read data is registered, so it arrives in the cycle after its address
        cmp_hit = r_cmp && ring_rsp.valid && (ring_rsp.id == r_item.object_id);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.kind == doc_pkg::KIND_CLEAR) begin
                        n_ltr     = '0;
                        n_rtl     = '0;
                        do_result = 1'b1;
                    end else begin
                        n_item  = i_item;
                        n_addr  = '0;
                        n_hit   = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ring_req.rd_en = 1'b1;
                n_cmp = 1'b1;
                n_hit = r_hit | cmp_hit;
                if (r_addr == LAST_IDX) begin
                    n_state = S_LAST;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_LAST: begin
                counted = !(r_hit | cmp_hit) && qual_pass;
                if (counted) begin
                    ring_req.wr_en = 1'b1;
                    if (r_item.left_to_right) begin
                        n_ltr = r_ltr + 1'b1;
                    end else begin
                        n_rtl = r_rtl + 1'b1;
                    end
                end
                do_result = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_vld = do_result;
        n_out     = r_out;
        if (do_result) begin
            n_out.counted     = counted;
            n_out.ltr_count   = n_ltr;
            n_out.rtl_count   = n_rtl;
            n_out.total_count = (doc_pkg::CNT_BITS+1)'(n_ltr)
                              + (doc_pkg::CNT_BITS+1)'(n_rtl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_hit     <= 1'b0;
            r_cmp     <= 1'b0;
            r_ltr     <= '0;
            r_rtl     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_hit     <= n_hit;
            r_cmp     <= n_cmp;
            r_ltr     <= n_ltr;
            r_rtl     <= n_rtl;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

[rtl/core/doc_chk.sv]
// Port-level checker for the directional object counter, bound to the top level.
// Depends on doc_pkg and directional_object_counter_top_assert.svh.
`default_nettype none

`include "directional_object_counter_top_assert.svh"

module doc_chk (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                start,
    input wire                                busy,
    input doc_pkg::t_in                       i_item,
    input wire                                o_valid,
    input doc_pkg::t_out                      o_result
);

    logic accept;
    logic acc_report;
    logic acc_clear;
    logic clear_ok;
    logic [doc_pkg::CNT_BITS:0] sum;

    assign accept     = start && !busy;
    assign acc_report = accept && (i_item.kind == doc_pkg::KIND_REPORT);
    assign acc_clear  = accept && (i_item.kind == doc_pkg::KIND_CLEAR);
    assign clear_ok   = o_valid && !o_result.counted
                     && (o_result.ltr_count == '0) && (o_result.rtl_count == '0);
    assign sum        = (doc_pkg::CNT_BITS+1)'(o_result.ltr_count)
                      + (doc_pkg::CNT_BITS+1)'(o_result.rtl_count);

    `DOC_ASSERT_NEXT(a_report_busy, acc_report, busy && !o_valid)
    `DOC_ASSERT_NEXT(a_clear_result, acc_clear, clear_ok)
    `DOC_ASSERT_NOW(a_valid_idle, o_valid, !busy)
    `DOC_ASSERT_NOW(a_total_sum, o_valid, o_result.total_count == sum)

endmodule

bind directional_object_counter_top doc_chk u_doc_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

[tb/sv/directional_object_counter_top_test.sv]
// Self-checking bench for directional_object_counter_top: directed and random
// object reports and clear words against an in-bench count predictor.
// Depends on doc_pkg and the RTL under rtl/core.

module directional_object_counter_top_test;
    import doc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_CYCLES = RECENT_DEPTH + 2;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    // Predicts counts from accepted words and checks each result in order.
    class count_tally;
        t_cfg                box;
        logic [ID_BITS-1:0]  seen_ids [RECENT_DEPTH];
        bit                  seen_valid [RECENT_DEPTH];
        int                  ring_ptr;
        bit [CNT_BITS-1:0]   ltr_n;
        bit [CNT_BITS-1:0]   rtl_n;
        t_out                expected_tallies [$];
        int                  errors;
        int                  words;
        int                  hits;
        int                  clears;

        function new();
            box = '0;
            ring_ptr = 0;
            ltr_n = '0;
            rtl_n = '0;
            errors = 0;
            words = 0;
            hits = 0;
            clears = 0;
            foreach (seen_valid[k]) seen_valid[k] = 1'b0;
        endfunction

        function void note_word(t_in it);
            t_out r;
            int   px, py, sx, w, wref, lft, tp, ht, travel;
            bit   fresh, hit;
            r = '0;
            words++;
            if (it.kind == KIND_CLEAR) begin
                ltr_n = '0;
                rtl_n = '0;
                clears++;
            end else begin
                px = it.pos_x;
                py = it.pos_y;
                sx = it.start_x;
                w = it.object_width;
                wref = box.ref_width;
                lft = box.ref_left;
                tp = box.ref_top;
                ht = box.ref_height;
                travel = (px >= sx) ? px - sx : sx - px;
                fresh = 1'b1;
                for (int k = 0; k < RECENT_DEPTH; k++)
                    if (seen_valid[k] && seen_ids[k] == it.object_id) fresh = 1'b0;
                // box edges are open; right/bottom computed without wrap
                hit = fresh && it.frames_alive > MIN_FRAMES && travel > wref
                    && 20 * w > 13 * wref && 2 * w < 3 * wref
                    && px > lft && px < lft + wref && py > tp && py < tp + ht;
                if (hit) begin
                    if (it.left_to_right) ltr_n = ltr_n + 1;
                    else rtl_n = rtl_n + 1;
                    seen_ids[ring_ptr] = it.object_id;
                    seen_valid[ring_ptr] = 1'b1;
                    ring_ptr = (ring_ptr + 1) % RECENT_DEPTH;
                    hits++;
                end
                r.counted = hit;
            end
            r.ltr_count = ltr_n;
            r.rtl_count = rtl_n;
            r.total_count = {1'b0, ltr_n} + {1'b0, rtl_n};
            expected_tallies.push_back(r);
        endfunction

        function void cmp_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_out got);
            t_out want;
            if (expected_tallies.size() == 0) begin
                $display("%0t: unexpected result word, actual counted=%0d total=%0d",
                         $time, got.counted, got.total_count);
                errors++;
                return;
            end
            want = expected_tallies.pop_front();
            cmp_field("counted", want.counted, got.counted);
            cmp_field("ltr_count", want.ltr_count, got.ltr_count);
            cmp_field("rtl_count", want.rtl_count, got.rtl_count);
            cmp_field("total_count", want.total_count, got.total_count);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_in                    i_item = '0;
    logic                   o_valid;
    t_out                   o_result;
    logic                   i_cfg_we = 1'b0;
    t_reg_idx               i_cfg_idx = REG_LEFT;
    logic [COORD_BITS-1:0]  i_cfg_data = '0;

    count_tally counts;
    int         cycle_n = 0;

    directional_object_counter_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result first: nothing accepted at this edge can already have a result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) counts.check_word(o_result);
            if (start && !busy) counts.note_word(i_item);
        end
    end

    // leaves start high; the caller lowers it or sends the next word
    task automatic send_word(t_in it);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        // the monitor may not have logged a word taken at this same edge yet
        @(posedge i_clk);
        while (counts.expected_tallies.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[COORD_BITS-1:0];
        @(posedge i_clk);
    endtask

    task automatic load_box(int lft, int tp, int wd, int ht);
        write_reg(REG_LEFT, lft);
        write_reg(REG_TOP, tp);
        write_reg(REG_WIDTH, wd);
        write_reg(REG_HEIGHT, ht);
        i_cfg_we <= 1'b0;
        counts.box.ref_left = lft[COORD_BITS-1:0];
        counts.box.ref_top = tp[COORD_BITS-1:0];
        counts.box.ref_width = wd[COORD_BITS-1:0];
        counts.box.ref_height = ht[COORD_BITS-1:0];
    endtask

    function automatic t_in mk_report(int id, int frames, int px, int py, int sx, int w,
                                      bit ltr);
        t_in it;
        it.kind = KIND_REPORT;
        it.object_id = id[ID_BITS-1:0];
        it.frames_alive = frames[FRAME_BITS-1:0];
        it.pos_x = px[COORD_BITS-1:0];
        it.pos_y = py[COORD_BITS-1:0];
        it.start_x = sx[COORD_BITS-1:0];
        it.object_width = w[COORD_BITS-1:0];
        it.left_to_right = ltr;
        return it;
    endfunction

    function automatic t_in rand_word();
        return mk_report($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, 1));
    endfunction

    // small id pool so repeats hit the ring and old entries get evicted
    function automatic int pick_id();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 47);
        return $urandom_range(0, 65535);
    endfunction

    // report that passes every test for the current box, or misses one by a
    // single step when bend is set; plain noise if the box admits nothing
    function automatic t_in shape_report(bit bend);
        int lft, tp, wr, ht, px, py, sx, w, lo, hi, pxmax, pymax, frames;
        bit can_dn, can_up;
        lft = counts.box.ref_left;
        tp = counts.box.ref_top;
        wr = counts.box.ref_width;
        ht = counts.box.ref_height;
        pxmax = (lft + wr - 1 > COORD_MAX) ? COORD_MAX : lft + wr - 1;
        pymax = (tp + ht - 1 > COORD_MAX) ? COORD_MAX : tp + ht - 1;
        lo = 13 * wr / 20 + 1;
        hi = (3 * wr - 1) / 2;
        if (hi > COORD_MAX) hi = COORD_MAX;
        if (lft + 1 > pxmax || tp + 1 > pymax || lo > hi) return rand_word();
        px = $urandom_range(lft + 1, pxmax);
        py = $urandom_range(tp + 1, pymax);
        can_dn = px > wr;
        can_up = px + wr + 1 <= COORD_MAX;
        if (!can_dn && !can_up) return rand_word();
        if (can_dn && (!can_up || $urandom_range(0, 1)))
            sx = $urandom_range(0, px - wr - 1);
        else
            sx = $urandom_range(px + wr + 1, COORD_MAX);
        w = $urandom_range(lo, hi);
        frames = ($urandom_range(0, 3) == 0) ? MIN_FRAMES + 1 : $urandom_range(3, 65535);
        if (bend) begin
            case ($urandom_range(0, 7))
                0: frames = $urandom_range(0, MIN_FRAMES);
                1: px = lft;
                2: px = lft + wr;
                3: py = tp;
                4: py = tp + ht;
                5: sx = (px >= wr) ? px - wr : px + wr;
                6: w = lo - 1;
                default: w = hi + 1;
            endcase
        end
        return mk_report(pick_id(), frames, px, py, sx, w, $urandom_range(0, 1));
    endfunction

    initial begin
        t_in it;
        int  pick, n_set;
        bit  idling;
        counts = new();
        n_set = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset box has zero width: the size test can never pass
        send_word(mk_report(7, 100, 150, 200, 400, 150, 1'b1));
        send_word(mk_report(65535, 65535, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        it = '1;
        send_word(it);
        send_word('0);
        drain();

        load_box(100, 50, 200, 300);
        n_set++;
        send_word(mk_report(7, 3, 150, 200, 400, 150, 1'b1));
        send_word(mk_report(7, 3, 150, 200, 400, 150, 1'b1));     // id already counted
        send_word(mk_report(8, 9, 160, 100, 0, 150, 1'b0));
        send_word(mk_report(9, 2, 150, 200, 400, 150, 1'b1));     // too young
        send_word(mk_report(9, 5, 150, 200, 350, 150, 1'b1));     // travel equals width
        send_word(mk_report(9, 5, 150, 200, 400, 130, 1'b1));     // width at low bound
        send_word(mk_report(10, 5, 150, 200, 400, 131, 1'b0));
        send_word(mk_report(11, 5, 150, 200, 400, 300, 1'b1));    // width at high bound
        send_word(mk_report(11, 5, 150, 200, 400, 299, 1'b1));
        send_word(mk_report(12, 5, 100, 200, 400, 150, 1'b1));    // on the box edges
        send_word(mk_report(12, 5, 300, 200, 0, 150, 1'b1));
        send_word(mk_report(12, 5, 150, 50, 400, 150, 1'b1));
        send_word(mk_report(12, 5, 150, 350, 400, 150, 1'b1));
        send_word(mk_report(12, 5, 299, 349, 0, 150, 1'b0));
        it = '1;
        it.kind = KIND_CLEAR;
        send_word(it);
        send_word(mk_report(7, 3, 150, 200, 400, 150, 1'b1));     // ring survives clear
        send_word(mk_report(13, 3, 101, 51, 4095, 150, 1'b1));
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: load_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                1: load_box(0, 0, COORD_MAX, COORD_MAX);
                2: load_box(0, 0, 2, 2);
                3: load_box($urandom_range(2000, 3500), $urandom_range(0, 3000),
                            $urandom_range(1000, 2095), $urandom_range(16, 4095));
                4: load_box($urandom_range(0, 2000), $urandom_range(0, 3000),
                            $urandom_range(3, 15), $urandom_range(3, 15));
                default: load_box($urandom_range(0, 2000), $urandom_range(0, 3000),
                                  $urandom_range(16, 1200), $urandom_range(16, 1000));
            endcase
            n_set++;
            idling = (ph < 8);
            for (int k = 0; k < 80; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    it = rand_word();
                    it.kind = KIND_CLEAR;
                end else if (pick < 30) begin
                    it = rand_word();
                end else begin
                    it = shape_report($urandom_range(0, 2) == 0);
                end
                send_word(it);
                if (idling && $urandom_range(0, 3) == 0) begin
                    start <= 1'b0;
                    // sometimes let the scan finish before the gap starts
                    if ($urandom_range(0, 1)) begin
                        do @(posedge i_clk); while (busy);
                    end
                    repeat ($urandom_range(1, 7)) @(posedge i_clk);
                end
            end
            drain();
        end

        repeat (REPORT_CYCLES + 4) @(posedge i_clk);
        $display("Covered %0d words over %0d box settings: %0d reports counted, %0d clears.",
                 counts.words, n_set, counts.hits, counts.clears);
        $display("Mismatches: %0d", counts.errors);
        if (counts.errors == 0 && counts.expected_tallies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/doc_pkg.sv
rtl/core/doc_ring.sv
rtl/core/doc_qual.sv
rtl/core/directional_object_counter_top.sv
rtl/core/doc_chk.sv
tb/sv/directional_object_counter_top_test.sv
